// ===== src/cau_pkg.sv =====
// Shared types and constants for the column aggregate unit.
// No dependencies.
`default_nettype none
package cau_pkg;
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int JOB_CNT_W       = 32;
  localparam int Q_DEPTH         = 2;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    FN_SUM = 3'd0,
    FN_AVG = 3'd1,
    FN_MIN = 3'd2,
    FN_MAX = 3'd3,
    FN_CNT = 3'd4,
    FN_STD = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ACC,
    BK_CMP,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic [2:0]           func;
    logic [63:0]          sum;
    logic [127:0]         sq;
    logic [JOB_CNT_W-1:0] cnt;
    logic [63:0]          vmin;
    logic [63:0]          vmax;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage
`default_nettype wire

// ===== src/cau_queue.sv =====
// Two-entry job queue between front and back of the aggregate unit.
// Depends on cau_pkg.
`default_nettype none
module cau_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire cau_pkg::job_t push_job,
  input  wire logic          pop,
  output cau_pkg::job_t      head,
  output cau_pkg::q_stat_t   stat
);
  import cau_pkg::*;

  localparam int QAW = $clog2(Q_DEPTH);

  job_t           mem [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  assign head       = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == (QAW+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
endmodule
`default_nettype wire

// ===== src/cau_front.sv =====
// Front end: accepts beats, squares values, accumulates and emits a job per set.
// Depends on cau_pkg.
`default_nettype none
module cau_front #(
  parameter int DATA_WIDTH  = cau_pkg::DATA_WIDTH_DEF,
  parameter int COUNT_WIDTH = cau_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [2:0]       cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [31:0]      in_sample_value,
  input  wire logic             in_is_null,
  input  wire logic             in_last_item,
  input  wire cau_pkg::q_stat_t q_stat,
  output logic                  push,
  output cau_pkg::job_t         push_job
);
  import cau_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  logic [2:0]             func_r;
  logic                   valid1_r, null1_r, last1_r;
  logic [63:0]            v1_r;
  logic [31:0]            mag1_r;
  logic                   valid2_r, null2_r, last2_r;
  logic [63:0]            v2_r, sq2_r;
  logic [63:0]            sum_r, min_r, max_r;
  logic [127:0]           sq_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [63:0]            sum_nxt, min_nxt, max_nxt, v_in, mag_in;
  logic [127:0]           sq_nxt;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  logic                   adv, take;

  assign adv      = !(valid2_r && last2_r && q_stat.full);
  assign in_stall = !adv;
  assign take     = valid2_r && adv;
  assign v_in     = 64'(signed'(in_sample_value[DATA_WIDTH-1:0]));
  assign mag_in   = v_in[63] ? (64'd0 - v_in) : v_in;

  always_comb begin
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    cnt_nxt = cnt_r;
    min_nxt = min_r;
    max_nxt = max_r;
    if (!null2_r) begin
      sum_nxt = sum_r + v2_r;
      sq_nxt  = sq_r + {64'd0, sq2_r};
      if (cnt_r != CMAX) cnt_nxt = cnt_r + 1'b1;
      if ($signed(v2_r) < $signed(min_r)) min_nxt = v2_r;
      if ($signed(max_r) < $signed(v2_r)) max_nxt = v2_r;
    end
  end

  assign push           = take && last2_r;
  assign push_job.func  = func_r;
  assign push_job.sum   = sum_nxt;
  assign push_job.sq    = sq_nxt;
  assign push_job.cnt   = JOB_CNT_W'(cnt_nxt);
  assign push_job.vmin  = min_nxt;
  assign push_job.vmax  = max_nxt;

  always_ff @(posedge clk) begin
    if (adv) begin
      v1_r    <= v_in;
      mag1_r  <= mag_in[31:0];
      null1_r <= in_is_null;
      last1_r <= in_last_item;
      v2_r    <= v1_r;
      sq2_r   <= 64'(mag1_r) * 64'(mag1_r);
      null2_r <= null1_r;
      last2_r <= last1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_r   <= FN_SUM;
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
      sum_r    <= '0;
      sq_r     <= '0;
      cnt_r    <= '0;
      min_r    <= S64_MAX;
      max_r    <= S64_MIN;
    end else begin
      if (cfg_wr_en) func_r <= cfg_wr_data;
      if (adv) begin
        valid1_r <= in_valid;
        valid2_r <= valid1_r;
      end
      if (take) begin
        if (last2_r) begin
          sum_r <= '0;
          sq_r  <= '0;
          cnt_r <= '0;
          min_r <= S64_MAX;
          max_r <= S64_MIN;
        end else begin
          sum_r <= sum_nxt;
          sq_r  <= sq_nxt;
          cnt_r <= cnt_nxt;
          min_r <= min_nxt;
          max_r <= max_nxt;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/cau_back.sv =====
// Back end: finishes one job with a shared 32x32 multiplier, a bit-serial
// divider and a digit-serial square root. Depends on cau_pkg.
`default_nettype none
module cau_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cau_pkg::q_stat_t q_stat,
  input  wire cau_pkg::job_t    head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [63:0]           out_aggregate_value
);
  import cau_pkg::*;

  bk_state_t      state_r, state_nxt;
  logic [127:0]   sq_r, sq_nxt, a_r, a_nxt, b_r, b_nxt, num_r, num_nxt;
  logic [31:0]    n_r, n_nxt, ma, mb;
  logic [63:0]    mag_r, mag_nxt, prod_r, prod_nxt, nn_r, nn_nxt;
  logic [63:0]    rem_r, rem_nxt, d_r, d_nxt, root_r, root_nxt, res_r, res_nxt;
  logic [65:0]    srem_r, srem_nxt, srem_sh, trial;
  logic [64:0]    rem65;
  logic [3:0]     k_r, k_nxt;
  logic [6:0]     step_r, step_nxt;
  logic           neg_r, neg_nxt, avg_r, avg_nxt, dge, sge;
  logic           out_valid_r, out_valid_nxt;
  logic [63:0]    out_value_r, out_value_nxt, hmag, q;
  logic [127:0]   pwide;

  assign hmag    = head.sum[63] ? (64'd0 - head.sum) : head.sum;
  assign rem65   = {rem_r, num_r[127]};
  assign dge     = rem65 >= {1'b0, d_r};
  assign srem_sh = {srem_r[63:0], num_r[127:126]};
  assign trial   = {root_r, 2'b01};
  assign sge     = srem_sh >= trial;
  assign pwide   = {64'd0, prod_r};

  always_comb begin
    case (k_r)
      4'd0:    begin ma = sq_r[31:0];    mb = n_r; end
      4'd1:    begin ma = sq_r[63:32];   mb = n_r; end
      4'd2:    begin ma = sq_r[95:64];   mb = n_r; end
      4'd3:    begin ma = sq_r[127:96];  mb = n_r; end
      4'd4:    begin ma = mag_r[31:0];   mb = mag_r[31:0]; end
      4'd5:    begin ma = mag_r[31:0];   mb = mag_r[63:32]; end
      4'd6:    begin ma = mag_r[63:32];  mb = mag_r[31:0]; end
      4'd7:    begin ma = mag_r[63:32];  mb = mag_r[63:32]; end
      default: begin ma = n_r;           mb = n_r; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sq_nxt        = sq_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    num_nxt       = num_r;
    n_nxt         = n_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    nn_nxt        = nn_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    root_nxt      = root_r;
    res_nxt       = res_r;
    srem_nxt      = srem_r;
    k_nxt         = k_r;
    step_nxt      = step_r;
    neg_nxt       = neg_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    q             = '0;
    pop           = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          sq_nxt    = head.sq;
          n_nxt     = head.cnt;
          mag_nxt   = hmag;
          neg_nxt   = head.sum[63];
          res_nxt   = '0;
          state_nxt = BK_DONE;
          case (head.func)
            FN_SUM: res_nxt = head.sum;
            FN_AVG: begin
              if (head.cnt != '0) begin
                num_nxt   = {hmag, 64'd0};
                rem_nxt   = '0;
                d_nxt     = {32'd0, head.cnt};
                step_nxt  = 7'd63;
                avg_nxt   = 1'b1;
                state_nxt = BK_DIV;
              end
            end
            FN_MIN: res_nxt = head.vmin;
            FN_MAX: res_nxt = head.vmax;
            FN_CNT: res_nxt = {32'd0, head.cnt};
            FN_STD: begin
              if (head.cnt != '0) begin
                a_nxt     = '0;
                b_nxt     = '0;
                k_nxt     = '0;
                state_nxt = BK_MUL;
              end
            end
            default: res_nxt = '0;
          endcase
        end
      end
      BK_MUL: begin
        prod_nxt  = 64'(ma) * 64'(mb);
        state_nxt = BK_ACC;
      end
      BK_ACC: begin
        case (k_r)
          4'd0:    a_nxt  = a_r + pwide;
          4'd1:    a_nxt  = a_r + (pwide << 32);
          4'd2:    a_nxt  = a_r + (pwide << 64);
          4'd3:    a_nxt  = a_r + (pwide << 96);
          4'd4:    b_nxt  = b_r + pwide;
          4'd5:    b_nxt  = b_r + (pwide << 32);
          4'd6:    b_nxt  = b_r + (pwide << 32);
          4'd7:    b_nxt  = b_r + (pwide << 64);
          default: nn_nxt = prod_r;
        endcase
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r == 4'd8) ? BK_CMP : BK_MUL;
      end
      BK_CMP: begin
        if (b_r > a_r) begin
          res_nxt   = '0;
          state_nxt = BK_DONE;
        end else begin
          num_nxt   = a_r - b_r;
          rem_nxt   = '0;
          d_nxt     = nn_r;
          step_nxt  = 7'd127;
          avg_nxt   = 1'b0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        rem_nxt  = dge ? 64'(rem65 - {1'b0, d_r}) : rem65[63:0];
        num_nxt  = {num_r[126:0], dge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          if (avg_r) begin
            q         = num_nxt[63:0];
            res_nxt   = neg_r ? (64'd0 - q) : q;
            state_nxt = BK_DONE;
          end else begin
            root_nxt  = '0;
            srem_nxt  = '0;
            step_nxt  = 7'd63;
            state_nxt = BK_SQRT;
          end
        end
      end
      BK_SQRT: begin
        srem_nxt = sge ? (srem_sh - trial) : srem_sh;
        root_nxt = {root_r[62:0], sge};
        num_nxt  = num_r << 2;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          res_nxt   = root_nxt;
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    sq_r        <= sq_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    num_r       <= num_nxt;
    n_r         <= n_nxt;
    mag_r       <= mag_nxt;
    prod_r      <= prod_nxt;
    nn_r        <= nn_nxt;
    rem_r       <= rem_nxt;
    d_r         <= d_nxt;
    root_r      <= root_nxt;
    res_r       <= res_nxt;
    srem_r      <= srem_nxt;
    k_r         <= k_nxt;
    step_r      <= step_nxt;
    neg_r       <= neg_nxt;
    avg_r       <= avg_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_aggregate_value = out_value_r;
endmodule
`default_nettype wire

// ===== src/column_aggregate_unit.sv =====
// Column aggregate unit top level: front accumulator, job queue, back finisher.
// Depends on cau_pkg, cau_front, cau_queue, cau_back.
//
// The front takes one beat per cycle through a two-stage square-and-accumulate
// pipe; a last beat hands a job to a two-entry queue and clears the running
// state, so the next set streams in at once. The back finishes jobs one at a
// time: sum, minimum, maximum and count need no arithmetic, average uses the
// 64-step bit-serial divider, and standard deviation uses the shared 32x32
// multiplier, 128 divider steps and 64 square-root steps. The front stalls
// only when a last beat finds the queue full.
`default_nettype none
module column_aggregate_unit #(
  parameter int DATA_WIDTH  = cau_pkg::DATA_WIDTH_DEF,
  parameter int COUNT_WIDTH = cau_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_sample_value,
  input  wire logic        in_is_null,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_aggregate_value
);
  import cau_pkg::*;

  job_t    push_job, head;
  q_stat_t q_stat;
  logic    push, pop;

  cau_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_value(in_sample_value),
    .in_is_null     (in_is_null),
    .in_last_item   (in_last_item),
    .q_stat         (q_stat),
    .push           (push),
    .push_job       (push_job)
  );

  cau_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  cau_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_aggregate_value(out_aggregate_value)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("job queue underflow");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !q_stat.full)
    else $error("output or queue busy after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_stat.full)
    else $error("input stalled with queue space free");
endmodule
`default_nettype wire
